### design/hid_descriptor_digitizer_strip_macros.svh
// assertion macros for the descriptor strip filter
`ifndef HID_DESCRIPTOR_DIGITIZER_STRIP_MACROS_SVH
`define HID_DESCRIPTOR_DIGITIZER_STRIP_MACROS_SVH

// condition must hold at every edge out of reset
`define HDDS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HDDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/hdds_pkg.sv
// shared types and constants of the descriptor strip filter
package hdds_pkg;

	localparam int KEPT_W  = 16;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	localparam logic [7:0] PAGE_HEADER = 8'h05;
	localparam logic [7:0] OPEN_COLL   = 8'hA1;
	localparam logic [7:0] CLOSE_COLL  = 8'hC0;
	localparam logic [1:0] SIZE_FOUR   = 2'd3;

	localparam logic CFG_STRIP_ENABLE = 1'b0;
	localparam logic CFG_STRIP_PAGE   = 1'b1;

	// number of kept bytes an item releases
	localparam logic [1:0] EMIT_NONE = 2'd0;
	localparam logic [1:0] EMIT_ONE  = 2'd1;
	localparam logic [1:0] EMIT_TWO  = 2'd2;

	typedef enum logic [2:0] {
		MODE_HEADER = 3'b001,
		MODE_DATA   = 3'b010,
		MODE_SKIP   = 3'b100
	} parse_mode_t;

	typedef struct packed {
		logic       strip_enable;
		logic [7:0] strip_page;
	} cfg_t;

	// one queued command for the back end: b0 goes out first
	typedef struct packed {
		logic [1:0] emit;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       last;
	} cmd_t;

endpackage

### design/hdds_front.sv
// front end: walks short items and decides which bytes are kept
module hdds_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          last_byte,
	input  hdds_pkg::cfg_t cfg,
	output logic          push,
	output hdds_pkg::cmd_t cmd
);
	import hdds_pkg::*;

	parse_mode_t mode_q, mode_d;
	logic [2:0]  data_left_q, data_left_d;
	logic [7:0]  open_q, open_d, close_q, close_d;
	logic        held_q, held_d;
	logic [7:0]  open_inc, close_inc;
	logic [2:0]  data_dec;
	cmd_t        cmd_d;

	assign open_inc  = open_q + ((in_byte == OPEN_COLL) ? 8'd1 : 8'd0);
	assign close_inc = close_q + ((in_byte == CLOSE_COLL) ? 8'd1 : 8'd0);
	assign data_dec  = (data_left_q != 3'd0) ? data_left_q - 3'd1 : 3'd0;

	always_comb begin
		mode_d      = mode_q;
		data_left_d = data_left_q;
		open_d      = open_q;
		close_d     = close_q;
		held_d      = held_q;
		cmd_d.emit  = EMIT_NONE;
		cmd_d.b0    = in_byte;
		cmd_d.b1    = in_byte;
		cmd_d.last  = last_byte;
		if (held_q) begin
			held_d = 1'b0;
			if (cfg.strip_enable && in_byte == cfg.strip_page) begin
				// page byte itself opens the count
				open_d  = (in_byte == OPEN_COLL) ? 8'd1 : 8'd0;
				close_d = (in_byte == CLOSE_COLL) ? 8'd1 : 8'd0;
				mode_d  = MODE_SKIP;
			end else begin
				cmd_d.emit = EMIT_TWO;
				cmd_d.b0   = PAGE_HEADER;
				mode_d     = MODE_HEADER;
			end
		end else begin
			unique case (mode_q)
				MODE_SKIP: begin
					open_d  = open_inc;
					close_d = close_inc;
					if (open_inc != 8'd0 && open_inc == close_inc) begin
						open_d  = 8'd0;
						close_d = 8'd0;
						mode_d  = MODE_HEADER;
					end
				end
				MODE_DATA: begin
					cmd_d.emit  = EMIT_ONE;
					data_left_d = data_dec;
					if (data_dec == 3'd0)
						mode_d = MODE_HEADER;
				end
				default: begin
					if (in_byte == PAGE_HEADER && !last_byte) begin
						held_d = 1'b1;
					end else begin
						cmd_d.emit  = EMIT_ONE;
						data_left_d = (in_byte[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, in_byte[1:0]};
						mode_d      = (in_byte[1:0] != 2'd0) ? MODE_DATA : MODE_HEADER;
					end
				end
			endcase
		end
		if (last_byte) begin
			mode_d      = MODE_HEADER;
			data_left_d = 3'd0;
			open_d      = 8'd0;
			close_d     = 8'd0;
			held_d      = 1'b0;
		end
	end

	assign cmd  = cmd_d;
	assign push = accept && (cmd_d.emit != EMIT_NONE || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_HEADER;
			data_left_q <= 3'd0;
			open_q      <= 8'd0;
			close_q     <= 8'd0;
			held_q      <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			data_left_q <= data_left_d;
			open_q      <= open_d;
			close_q     <= close_d;
			held_q      <= held_d;
		end
	end

endmodule

### design/hdds_queue.sv
// short command queue between the parser and the emitter
module hdds_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  hdds_pkg::cmd_t         push_cmd,
	input  logic                   pop,
	output hdds_pkg::cmd_t         head,
	output logic                   empty,
	output logic                   full,
	output logic [hdds_pkg::QCNT_W-1:0] count
);
	import hdds_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == QCNT_W'(0));
	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign count = cnt_q;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

### design/hdds_back.sv
// back end: turns queued commands into result items and keeps the count
module hdds_back #(
	parameter int MAX_DESC_LEN = 65535
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hdds_pkg::cmd_t             head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       phase,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       has_byte,
	output logic                       end_of_descriptor,
	output logic [hdds_pkg::KEPT_W-1:0] bytes_kept
);
	import hdds_pkg::*;

	localparam logic [KEPT_W-1:0] MAX_KEPT = KEPT_W'(MAX_DESC_LEN);

	logic              phase_q;
	logic [KEPT_W-1:0] kept_q, kept_next;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              has_q, end_q;
	logic [KEPT_W-1:0] count_q;
	logic              load_ok, take, has_d, end_d;
	logic [7:0]        byte_d;

	assign load_ok = !out_valid_q || !out_stall;
	assign take    = load_ok && !empty;
	assign has_d   = (head.emit != EMIT_NONE);
	assign byte_d  = phase_q ? head.b1 : head.b0;
	// end flag rides on the second byte of a released page prefix
	assign end_d   = head.last && (head.emit != EMIT_TWO || phase_q);
	assign kept_next = (has_d && kept_q < MAX_KEPT) ? kept_q + KEPT_W'(1) : kept_q;
	assign pop     = take && (head.emit != EMIT_TWO || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load_ok) begin
			out_valid_q <= take;
			if (take) begin
				phase_q <= (head.emit == EMIT_TWO) && !phase_q;
				kept_q  <= end_d ? '0 : kept_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q  <= has_d ? byte_d : 8'd0;
			has_q   <= has_d;
			end_q   <= end_d;
			count_q <= kept_next;
		end
	end

	assign phase             = phase_q;
	assign out_valid         = out_valid_q;
	assign out_byte          = byte_q;
	assign has_byte          = has_q;
	assign end_of_descriptor = end_q;
	assign bytes_kept        = count_q;

endmodule

### design/hid_descriptor_digitizer_strip.sv
// top level of the hid descriptor digitizer-collection strip filter
//
//  channel | signals                                          | direction
//  in      | in_valid, in_stall, in_byte, last_byte          | byte in
//  out     | out_valid, out_stall, out_byte, has_byte,        | result out
//          | end_of_descriptor, bytes_kept                    |
//  cfg     | cfg_we, cfg_index, cfg_wdata                     | register write
//
// one byte per cycle in while in_stall is low; a released page prefix gives two
// results, sent in turn by the emitter; the four-entry command queue absorbs them
// input reaches the result through the command queue and the emitter register
// in_stall is high only while the command queue is full
// asynchronous reset clears parser state, queue and kept count, no clearing pass
`include "hid_descriptor_digitizer_strip_macros.svh"

module hid_descriptor_digitizer_strip #(
	parameter int MAX_DESC_LEN = 65535
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        has_byte,
	output logic                        end_of_descriptor,
	output logic [hdds_pkg::KEPT_W-1:0] bytes_kept,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [7:0]                  cfg_wdata
);
	import hdds_pkg::*;

	cfg_t              cfg_q;
	cmd_t              push_cmd, head;
	logic              accept, push, pop, empty, full, phase;
	logic [QCNT_W-1:0] qcount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_enable <= 1'b0;
			cfg_q.strip_page   <= 8'h0D;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STRIP_ENABLE: cfg_q.strip_enable <= cfg_wdata[0];
				CFG_STRIP_PAGE:   cfg_q.strip_page   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	hdds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.last_byte(last_byte),
		.cfg      (cfg_q),
		.push     (push),
		.cmd      (push_cmd)
	);

	hdds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full),
		.count   (qcount)
	);

	hdds_back #(
		.MAX_DESC_LEN(MAX_DESC_LEN)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.empty            (empty),
		.pop              (pop),
		.phase            (phase),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_byte         (out_byte),
		.has_byte         (has_byte),
		.end_of_descriptor(end_of_descriptor),
		.bytes_kept       (bytes_kept)
	);

	`HDDS_ASSERT_ALWAYS(a_queue_bound, clk, arst_n, qcount <= QCNT_W'(QDEPTH), "queue overfilled")
	`HDDS_ASSERT_IMPLY(a_phase_has_cmd, clk, arst_n, phase, !empty, "second byte with empty queue")
	`HDDS_ASSERT_IMPLY(a_empty_is_end, clk, arst_n, out_valid && !has_byte, end_of_descriptor, "empty result not at end")
	`HDDS_ASSERT_IMPLY(a_kept_nonzero, clk, arst_n, out_valid && has_byte, bytes_kept != '0, "kept byte with zero count")

endmodule
